/* rtl/ssc_pkg.sv */
// package for the sphere-sphere contact test: widths and payload types
package ssc_pkg;

	localparam int COORD_BITS_DEF = 24;
	localparam int FRAC_BITS_DEF = 12;
	localparam int NORM_FRAC = 14;
	localparam int NORM_W = 16;
	localparam int CW = 24;
	localparam int RW = CW - 1;
	localparam int DW = CW + 1;
	localparam int SQW = 2 * DW + 2;
	localparam int ROOTW = SQW / 2;
	localparam int QW = NORM_FRAC + 2;
	localparam int NUMW = DW + NORM_FRAC + 1;
	localparam logic [NORM_W-1:0] NORM_ONE = NORM_W'(1 << NORM_FRAC);

	typedef struct packed {
		logic signed [CW-1:0] center_a_x;
		logic signed [CW-1:0] center_a_y;
		logic signed [CW-1:0] center_a_z;
		logic signed [CW-1:0] center_b_x;
		logic signed [CW-1:0] center_b_y;
		logic signed [CW-1:0] center_b_z;
		logic [RW-1:0] radius_a;
		logic [RW-1:0] radius_b;
	} ssc_in_t;

	typedef struct packed {
		logic collided;
		logic signed [NORM_W-1:0] normal_x;
		logic signed [NORM_W-1:0] normal_y;
		logic signed [NORM_W-1:0] normal_z;
		logic [CW-1:0] depth;
	} ssc_out_t;

	// work carried from cell to cell
	typedef struct packed {
		logic valid;
		logic hit;
		logic coinc;
		logic [2:0] neg;
		logic [DW-1:0] mag_x;
		logic [DW-1:0] mag_y;
		logic [DW-1:0] mag_z;
		logic [RW-1:0] radius_a;
		logic [CW-1:0] rsum;
		logic [SQW-1:0] rem;
		logic [ROOTW-1:0] root;
		logic [NUMW-1:0] rem_x;
		logic [NUMW-1:0] rem_y;
		logic [NUMW-1:0] rem_z;
		logic [QW-1:0] q_x;
		logic [QW-1:0] q_y;
		logic [QW-1:0] q_z;
	} ssc_tok_t;

endpackage

/* rtl/ssc_root_cell.sv */
// one square-root digit cell: settles one bit of the distance per stage
module ssc_root_cell
	import ssc_pkg::ssc_tok_t;
#(
	parameter int STEP = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  ssc_tok_t tok_in,
	output ssc_tok_t tok_out
);
	import ssc_pkg::*;

	localparam int SH = 2 * (ROOTW - 1 - STEP);

	logic [SQW+1:0] trial;
	logic [SQW+1:0] cand;
	ssc_tok_t nxt;
	ssc_tok_t tok_q;
	logic valid_q;

	always_comb begin
		nxt = tok_in;
		cand = {(SQW + 2)'({tok_in.root, 2'b01})} << SH;
		trial = {2'b00, tok_in.rem};
		if (trial >= cand) begin
			nxt.rem = SQW'(trial - cand);
			nxt.root = {tok_in.root[ROOTW-2:0], 1'b1};
		end else begin
			nxt.root = {tok_in.root[ROOTW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= nxt;
	end

	always_comb begin
		tok_out = tok_q;
		tok_out.valid = valid_q;
	end
endmodule

/* rtl/ssc_div_cell.sv */
// one restoring-division cell: one quotient bit for each normal component
module ssc_div_cell
	import ssc_pkg::ssc_tok_t;
(
	input  logic clk,
	input  logic arst_n,
	input  logic [2:0] num_bits,
	input  ssc_tok_t tok_in,
	output ssc_tok_t tok_out
);
	import ssc_pkg::*;

	logic [NUMW:0] dv;
	logic [NUMW:0] tx, ty, tz;
	ssc_tok_t nxt;
	ssc_tok_t tok_q;
	logic valid_q;

	always_comb begin
		nxt = tok_in;
		dv = (NUMW + 1)'(tok_in.root);
		tx = {tok_in.rem_x, num_bits[2]};
		ty = {tok_in.rem_y, num_bits[1]};
		tz = {tok_in.rem_z, num_bits[0]};
		nxt.q_x = {tok_in.q_x[QW-2:0], tx >= dv};
		nxt.q_y = {tok_in.q_y[QW-2:0], ty >= dv};
		nxt.q_z = {tok_in.q_z[QW-2:0], tz >= dv};
		nxt.rem_x = (tx >= dv) ? NUMW'(tx - dv) : NUMW'(tx);
		nxt.rem_y = (ty >= dv) ? NUMW'(ty - dv) : NUMW'(ty);
		nxt.rem_z = (tz >= dv) ? NUMW'(tz - dv) : NUMW'(tz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= nxt;
	end

	always_comb begin
		tok_out = tok_q;
		tok_out.valid = valid_q;
	end
endmodule

/* rtl/sphere_sphere_contact.sv */
// top level of the sphere-sphere contact test
// Fully pipelined: a new sphere pair is taken every cycle and busy is never
// raised. Each transaction passes 3 + ROOTW + 1 + QW + 1 register stages
// (47 at 24-bit coordinates: three front stages, one cell per distance bit,
// one seed stage, one cell per normal quotient bit and the output register).
// done rises together with the registered result, for one cycle per transaction.
// The receiver cannot stall, so results leave on the cycle they are ready.
module sphere_sphere_contact
	import ssc_pkg::ssc_in_t, ssc_pkg::ssc_out_t;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  ssc_in_t in_data,
	output logic done,
	output ssc_out_t out_data
);
	import ssc_pkg::*;

	localparam int NR = ROOTW;
	localparam int ND = QW;

	logic v_s1, v_s2, v_s3;
	logic signed [DW-1:0] dx_s1, dy_s1, dz_s1;
	logic [RW-1:0] ra_s1;
	logic [CW-1:0] rsum_s1;
	logic [2*DW-1:0] sx_s2, sy_s2, sz_s2;
	logic [2*CW-1:0] r2_s2;
	logic [DW-1:0] mx_s2, my_s2, mz_s2;
	logic [2:0] neg_s2;
	logic [RW-1:0] ra_s2;
	logic [CW-1:0] rsum_s2;
	logic [DW-1:0] ax, ay, az;
	logic [SQW-1:0] d2;
	logic [ROOTW-1:0] half;
	ssc_tok_t head, head_s3, pre, pre_q;
	logic v_pre_q;
	ssc_tok_t rchain [NR+1];
	ssc_tok_t dchain [ND+1];
	logic [NUMW-1:0] nx_q [ND];
	logic [NUMW-1:0] ny_q [ND];
	logic [NUMW-1:0] nz_q [ND];
	ssc_out_t res;
	logic done_q;
	ssc_out_t out_q;

	assign busy = 1'b0;
	assign ax = dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1);
	assign ay = dy_s1[DW-1] ? DW'(-dy_s1) : DW'(dy_s1);
	assign az = dz_s1[DW-1] ? DW'(-dz_s1) : DW'(dz_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= DW'(in_data.center_b_x) - DW'(in_data.center_a_x);
		dy_s1 <= DW'(in_data.center_b_y) - DW'(in_data.center_a_y);
		dz_s1 <= DW'(in_data.center_b_z) - DW'(in_data.center_a_z);
		ra_s1 <= in_data.radius_a;
		rsum_s1 <= CW'(in_data.radius_a) + CW'(in_data.radius_b);
		sx_s2 <= ax * ax;
		sy_s2 <= ay * ay;
		sz_s2 <= az * az;
		r2_s2 <= rsum_s1 * rsum_s1;
		mx_s2 <= ax;
		my_s2 <= ay;
		mz_s2 <= az;
		neg_s2 <= {dx_s1[DW-1], dy_s1[DW-1], dz_s1[DW-1]};
		ra_s2 <= ra_s1;
		rsum_s2 <= rsum_s1;
	end

	assign d2 = SQW'(sx_s2) + SQW'(sy_s2) + SQW'(sz_s2);

	always_comb begin
		head = '0;
		head.valid = v_s2;
		head.hit = d2 <= SQW'(r2_s2);
		head.coinc = d2 == '0;
		head.neg = neg_s2;
		head.mag_x = mx_s2;
		head.mag_y = my_s2;
		head.mag_z = mz_s2;
		head.radius_a = ra_s2;
		head.rsum = rsum_s2;
		head.rem = d2;
	end

	always_ff @(posedge clk) begin
		head_s3 <= head;
	end

	always_comb begin
		rchain[0] = head_s3;
		rchain[0].valid = v_s3;
	end

	for (genvar i = 0; i < NR; i++) begin : g_root
		ssc_root_cell #(.STEP(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .tok_in(rchain[i]), .tok_out(rchain[i+1])
		);
	end

	// seed the divider with round-half offset: (mag << 14) + dist/2
	always_comb begin
		pre = rchain[NR];
		half = rchain[NR].root >> 1;
		if (rchain[NR].root == '0) begin
			pre.root = ROOTW'(1);
		end
		pre.rem_x = '0;
		pre.rem_y = '0;
		pre.rem_z = '0;
		pre.q_x = '0;
		pre.q_y = '0;
		pre.q_z = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_pre_q <= 1'b0;
		end else begin
			v_pre_q <= rchain[NR].valid;
		end
	end

	// numerator kept aside; divider consumes its low bits msb-first through a shift line
	always_ff @(posedge clk) begin
		pre_q <= pre;
		nx_q[0] <= NUMW'((NUMW'(rchain[NR].mag_x) << NORM_FRAC) + NUMW'(half));
		ny_q[0] <= NUMW'((NUMW'(rchain[NR].mag_y) << NORM_FRAC) + NUMW'(half));
		nz_q[0] <= NUMW'((NUMW'(rchain[NR].mag_z) << NORM_FRAC) + NUMW'(half));
		for (int k = 1; k < ND; k++) begin
			nx_q[k] <= nx_q[k-1];
			ny_q[k] <= ny_q[k-1];
			nz_q[k] <= nz_q[k-1];
		end
	end

	// partial remainder starts as the numerator's top bits
	always_comb begin
		dchain[0] = pre_q;
		dchain[0].valid = v_pre_q;
		dchain[0].rem_x = nx_q[0] >> ND;
		dchain[0].rem_y = ny_q[0] >> ND;
		dchain[0].rem_z = nz_q[0] >> ND;
	end

	for (genvar j = 0; j < ND; j++) begin : g_div
		ssc_div_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.num_bits({nx_q[j][ND-1-j], ny_q[j][ND-1-j], nz_q[j][ND-1-j]}),
			.tok_in(dchain[j]), .tok_out(dchain[j+1])
		);
	end

	function automatic logic [NORM_W-1:0] fin(input logic [QW-1:0] q, input logic n);
		logic [NORM_W-1:0] m;
		begin
			m = (NORM_W'(q) > NORM_ONE) ? NORM_ONE : NORM_W'(q);
			fin = n ? NORM_W'(-m) : m;
		end
	endfunction

	always_comb begin
		res = '0;
		if (dchain[ND].hit) begin
			res.collided = 1'b1;
			if (dchain[ND].coinc) begin
				res.normal_y = NORM_ONE;
				res.depth = CW'(dchain[ND].radius_a);
			end else begin
				res.normal_x = fin(dchain[ND].q_x, dchain[ND].neg[2]);
				res.normal_y = fin(dchain[ND].q_y, dchain[ND].neg[1]);
				res.normal_z = fin(dchain[ND].q_z, dchain[ND].neg[0]);
				res.depth = CW'(dchain[ND].rsum - CW'(dchain[ND].root));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dchain[ND].valid;
		end
	end

	always_ff @(posedge clk) begin
		out_q <= res;
	end

	assign done = done_q;
	assign out_data = out_q;
endmodule

/* rtl/ssc_checker.sv */
// port-level checker for the sphere-sphere contact test, bound to the top level
module ssc_checker
	import ssc_pkg::ssc_out_t;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input ssc_out_t out_data
);
	import ssc_pkg::*;

	localparam int LAT = 3 + ROOTW + 1 + QW + 1;

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !out_data.collided |-> out_data.depth == '0 && out_data.normal_x == '0
		&& out_data.normal_y == '0 && out_data.normal_z == '0)
		else $error("miss with nonzero fields");
	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $signed(out_data.normal_y) <= $signed(NORM_ONE)
		&& $signed(out_data.normal_y) >= -$signed(NORM_ONE))
		else $error("normal out of range");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("result missing after fixed latency");
endmodule

bind sphere_sphere_contact ssc_checker u_ssc_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .out_data(out_data)
);
